// ===== src/pmhb_pkg.sv =====
// Shared constants, command codes, control structs and boundary direction math.
package pmhb_pkg;

    // Grid size defaults.
    localparam int RINGS_DEF   = 20;
    localparam int SECTORS_DEF = 60;

    // Register reset values.
    localparam logic        [14:0] MAX_RADIUS_RST    = 15'd8000;
    localparam logic signed [15:0] HEIGHT_OFFSET_RST = 16'sd200;

    // Configuration register indexes.
    localparam logic [0:0] REG_MAX_RADIUS    = 1'd0;
    localparam logic [0:0] REG_HEIGHT_OFFSET = 1'd1;

    // Input command codes.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Port widths.
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 24;
    localparam int CFG_W    = 16;
    localparam int ENTRY_W  = 18;

    // Boundary direction vectors carry 45 fraction bits plus sign headroom.
    localparam int  DIR_W     = 47;
    localparam int  DIR_FRAC  = 45;
    localparam real DEG2RAD   = 0.017453292519943295;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic prep;
        logic range;
        logic limit;
        logic step_mul;
        logic step_cross;
        logic step_decide;
        logic cell_addr;
        logic read_addr;
        logic ram_rd;
        logic update;
        logic clr_start;
        logic clr_wr;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drop;
        logic last_step;
        logic clr_done;
        logic out_free;
    } dp_status_t;

    // Direction of boundary k of a grid with the given sector count. Multiples of
    // 45 degrees are exact; other directions are rounded to 45 fraction bits.
    function automatic logic signed [DIR_W-1:0] dir_comp(input int k, input int sectors,
                                                         input logic want_y);
        int     a;
        int     den;
        int     oct;
        int     rem;
        real    th;
        longint cu;
        longint su;
        longint vx;
        longint vy;
        longint tx;
        a   = 360 * k;
        den = 45 * sectors;
        oct = 0;
        rem = a;
        while (rem >= den) begin
            rem = rem - den;
            oct = oct + 1;
        end
        th = real'(rem) * DEG2RAD * (real'(sectors) ** (-1.0));
        if (rem == 0) begin
            cu = 64'sd1 <<< DIR_FRAC;
            su = 64'sd0;
        end else begin
            cu = longint'($cos(th) * (2.0 ** DIR_FRAC));
            su = longint'($sin(th) * (2.0 ** DIR_FRAC));
        end
        if (oct % 2 == 1) begin
            vx = cu - su;
            vy = cu + su;
        end else begin
            vx = cu;
            vy = su;
        end
        case ((oct >> 1) & 3)
            1: begin
                tx = vx;
                vx = -vy;
                vy = tx;
            end
            2: begin
                vx = -vx;
                vy = -vy;
            end
            3: begin
                tx = vx;
                vx = vy;
                vy = -tx;
            end
            default: begin
                tx = vx;
            end
        endcase
        return want_y ? DIR_W'(vy) : DIR_W'(vx);
    endfunction

endpackage

// ===== src/polar_max_height_binning_top.sv =====
// Top level of the polar maximum-height grid: controller, datapath and cell store.
// The block takes one transaction at a time. A clear is a sweep that writes one cell
// of the store per cycle; the same sweep runs after reset and no transaction is taken
// until it ends. A point passes through height and squared range, then the range
// limit, a bitwise search for ring and sector in which each bit takes products, a
// cross product and a decision, and a read-modify-write of the store. A read waits
// for the previous result to leave the output register. A point beyond the maximum
// radius is dropped after the range limit. Configuration writes take effect at once.
module polar_max_height_binning_top #(
    parameter int RINGS   = pmhb_pkg::RINGS_DEF,
    parameter int SECTORS = pmhb_pkg::SECTORS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command[1:0], point_x[17:2], point_y[33:18], point_z[49:34],
    // read_ring[54:50], read_sector[60:55], zero fill above
    input  logic [pmhb_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_height[16:0], occupied[17], zero fill above
    output logic [pmhb_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [pmhb_pkg::CFG_W-1:0]    cfg_wdata
);

    pmhb_pkg::ctrl_cmd_t  cmd;
    pmhb_pkg::dp_status_t status;

    pmhb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tdata[1:0]),
        .status   (status),
        .cmd      (cmd)
    );

    pmhb_dp #(
        .RINGS   (RINGS),
        .SECTORS (SECTORS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== src/pmhb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmhb_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1200
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pmhb_ctrl.sv =====
// Controller state machine that sequences clear sweeps, point binning and cell reads.
module pmhb_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             in_cmd,
    input  pmhb_pkg::dp_status_t   status,
    output pmhb_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_PREP    = 14'b00000000000100,
        ST_RANGE   = 14'b00000000001000,
        ST_LIMIT   = 14'b00000000010000,
        ST_MUL     = 14'b00000000100000,
        ST_CROSS   = 14'b00000001000000,
        ST_DECIDE  = 14'b00000010000000,
        ST_ADDR    = 14'b00000100000000,
        ST_FETCH   = 14'b00001000000000,
        ST_UPDATE  = 14'b00010000000000,
        ST_RADDR   = 14'b00100000000000,
        ST_RFETCH  = 14'b01000000000000,
        ST_RESULT  = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts with a sweep that empties the grid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    case (in_cmd)
                        pmhb_pkg::CMD_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        pmhb_pkg::CMD_ADD: begin
                            state_next = ST_PREP;
                        end
                        pmhb_pkg::CMD_READ: begin
                            state_next = ST_RADDR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_RANGE;
            end
            ST_RANGE: begin
                cmd.range  = 1'b1;
                state_next = ST_LIMIT;
            end
            ST_LIMIT: begin
                cmd.limit  = 1'b1;
                state_next = status.drop ? ST_IDLE : ST_MUL;
            end
            ST_MUL: begin
                cmd.step_mul = 1'b1;
                state_next   = ST_CROSS;
            end
            ST_CROSS: begin
                cmd.step_cross = 1'b1;
                state_next     = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.step_decide = 1'b1;
                state_next      = status.last_step ? ST_ADDR : ST_MUL;
            end
            ST_ADDR: begin
                cmd.cell_addr = 1'b1;
                state_next    = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.ram_rd = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RADDR: begin
                cmd.read_addr = 1'b1;
                state_next    = ST_RFETCH;
            end
            ST_RFETCH: begin
                cmd.ram_rd = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pmhb_dp.sv =====
// Datapath: configuration registers, range and angle search, cell store and result register.
module pmhb_dp #(
    parameter int RINGS   = pmhb_pkg::RINGS_DEF,
    parameter int SECTORS = pmhb_pkg::SECTORS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pmhb_pkg::ctrl_cmd_t             cmd,
    output pmhb_pkg::dp_status_t            status,
    input  logic [pmhb_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [pmhb_pkg::CFG_W-1:0]      cfg_wdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pmhb_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int CELLS  = RINGS * SECTORS;
    localparam int AW     = $clog2(CELLS);
    localparam int SW     = $clog2(SECTORS);
    localparam int IW_R   = $clog2(RINGS + 1);
    localparam int IW_S   = $clog2(SECTORS + 1);
    localparam int IW     = (IW_R > IW_S) ? IW_R : IW_S;
    localparam int RSQ    = RINGS * RINGS;
    localparam int RSQ_W  = $clog2(RSQ + 1);
    localparam int LIM_W  = 32 + RSQ_W;
    localparam int KSQ_W  = 2 * IW;
    localparam int KR_W   = KSQ_W + 30;
    localparam int CMP_W  = KR_W + LIM_W;
    localparam int DW     = pmhb_pkg::DIR_W;
    localparam int EW     = pmhb_pkg::ENTRY_W;

    // Input transaction and configuration registers.
    logic signed [15:0] x_reg, y_reg, z_reg;
    logic        [4:0]  rd_ring_reg;
    logic        [5:0]  rd_sec_reg;
    logic        [14:0] max_radius_reg;
    logic signed [15:0] height_offset_reg;

    // Range and height pipeline.
    logic signed [16:0]      h_reg;
    logic        [31:0]      xx_reg, yy_reg, d2_reg;
    logic        [29:0]      rr_reg;
    logic        [LIM_W-1:0] lim_reg;
    logic                    upper_reg, origin_reg;
    logic signed [31:0]      xx_full, yy_full;

    // Search state.
    logic [IW-1:0]   bit_reg, ring_ans_reg, sec_ans_reg;
    logic [IW-1:0]   ring_trial, sec_trial;
    logic [SW-1:0]   sec_idx;
    logic [KSQ_W-1:0] ksq_reg;
    logic [KR_W-1:0]  kr_reg;
    logic signed [38:0] ph_a_reg, ph_b_reg;
    logic signed [40:0] pl_a_reg, pl_b_reg;
    logic signed [39:0] hi_diff;
    logic signed [41:0] lo_diff;
    logic signed [63:0] cross_reg;
    logic               pred_ring, pred_sec, cross_pos, low_half;

    // Boundary direction table.
    logic signed [DW-1:0] dir_x_tab [SECTORS];
    logic signed [DW-1:0] dir_y_tab [SECTORS];
    logic signed [DW-1:0] dx, dy;
    logic signed [22:0]   dxh, dyh;
    logic signed [24:0]   dxl, dyl;

    // Cell store access.
    logic [AW-1:0] addr_reg, clr_cnt_reg;
    logic          inrange_reg;
    logic          ram_we, needs_write;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    // Result register.
    logic        m_valid_reg;
    logic [16:0] m_height_reg;
    logic        m_occ_reg;

    for (genvar gk = 0; gk < SECTORS; gk++) begin : g_dir
        assign dir_x_tab[gk] = pmhb_pkg::dir_comp(gk, SECTORS, 1'b0);
        assign dir_y_tab[gk] = pmhb_pkg::dir_comp(gk, SECTORS, 1'b1);
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_radius_reg    <= pmhb_pkg::MAX_RADIUS_RST;
            height_offset_reg <= pmhb_pkg::HEIGHT_OFFSET_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                pmhb_pkg::REG_MAX_RADIUS:    max_radius_reg    <= cfg_wdata[14:0];
                pmhb_pkg::REG_HEIGHT_OFFSET: height_offset_reg <= cfg_wdata;
                default:                     max_radius_reg    <= max_radius_reg;
            endcase
        end
    end

    // Input fields are captured when a transaction is accepted.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg       <= s_tdata[17:2];
            y_reg       <= s_tdata[33:18];
            z_reg       <= s_tdata[49:34];
            rd_ring_reg <= s_tdata[54:50];
            rd_sec_reg  <= s_tdata[60:55];
        end
    end

    assign xx_full = x_reg * x_reg;
    assign yy_full = y_reg * y_reg;

    // Height, squared range and boundary limit, one step per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            h_reg  <= 17'(z_reg) + 17'(height_offset_reg);
            xx_reg <= xx_full;
            yy_reg <= yy_full;
            rr_reg <= 30'(max_radius_reg) * 30'(max_radius_reg);
        end
        if (cmd.range) begin
            d2_reg <= xx_reg + yy_reg;
        end
        if (cmd.limit) begin
            lim_reg    <= LIM_W'(d2_reg) * LIM_W'(RSQ);
            upper_reg  <= (y_reg > 0) || ((y_reg == 0) && (x_reg > 0));
            origin_reg <= (x_reg == 0) && (y_reg == 0);
        end
    end

    assign status.drop = (32'(rr_reg) < d2_reg);

    // Trial indexes of the bitwise search.
    assign ring_trial = ring_ans_reg | bit_reg;
    assign sec_trial  = sec_ans_reg | bit_reg;
    assign sec_idx    = (sec_trial <= IW'(SECTORS - 1)) ? sec_trial[SW-1:0] : '0;
    assign dx  = dir_x_tab[sec_idx];
    assign dy  = dir_y_tab[sec_idx];
    assign dxh = dx[DW-1:24];
    assign dyh = dy[DW-1:24];
    assign dxl = {1'b0, dx[23:0]};
    assign dyl = {1'b0, dy[23:0]};

    assign hi_diff = 40'(ph_a_reg) - 40'(ph_b_reg);
    assign lo_diff = 42'(pl_a_reg) - 42'(pl_b_reg);

    // Search decisions: boundary below the point, ring limit below the range.
    assign cross_pos = !cross_reg[63] && (cross_reg != '0);
    assign low_half  = ({1'b0, sec_trial} << 1) >= (IW + 1)'(SECTORS);
    assign pred_sec  = (sec_trial <= IW'(SECTORS - 1)) && !origin_reg &&
                       (low_half ? (!upper_reg && cross_pos) : (!upper_reg || cross_pos));
    assign pred_ring = (ring_trial <= IW'(RINGS - 1)) &&
                       (CMP_W'(kr_reg) < CMP_W'(lim_reg));

    // Search datapath: partial products, cross product, then the decision.
    always_ff @(posedge aclk) begin
        if (cmd.limit) begin
            bit_reg      <= IW'(1) << (IW - 1);
            ring_ans_reg <= '0;
            sec_ans_reg  <= '0;
        end
        if (cmd.step_mul) begin
            ph_a_reg <= dxh * y_reg;
            ph_b_reg <= dyh * x_reg;
            pl_a_reg <= dxl * y_reg;
            pl_b_reg <= dyl * x_reg;
            ksq_reg  <= KSQ_W'(ring_trial) * KSQ_W'(ring_trial);
        end
        if (cmd.step_cross) begin
            cross_reg <= (64'(hi_diff) <<< 24) + 64'(lo_diff);
            kr_reg    <= KR_W'(ksq_reg) * KR_W'(rr_reg);
        end
        if (cmd.step_decide) begin
            if (pred_ring) begin
                ring_ans_reg <= ring_trial;
            end
            if (pred_sec) begin
                sec_ans_reg <= sec_trial;
            end
            bit_reg <= bit_reg >> 1;
        end
    end

    assign status.last_step = bit_reg[0];

    // Cell address for a point or a read.
    always_ff @(posedge aclk) begin
        if (cmd.cell_addr) begin
            addr_reg <= AW'(ring_ans_reg) * AW'(SECTORS) + AW'(sec_ans_reg);
        end else if (cmd.read_addr) begin
            inrange_reg <= (32'(rd_ring_reg) < 32'(RINGS)) && (32'(rd_sec_reg) < 32'(SECTORS));
            addr_reg    <= AW'(rd_ring_reg) * AW'(SECTORS) + AW'(rd_sec_reg);
        end
    end

    // Clear sweep counter.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_start) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign status.clr_done = (clr_cnt_reg == AW'(CELLS - 1));

    // Keep the larger height; the first point in an empty cell always wins.
    assign needs_write = !ram_rdata[EW-1] || ($signed(ram_rdata[16:0]) < h_reg);
    assign ram_we      = cmd.clr_wr || (cmd.update && needs_write);
    assign ram_waddr   = cmd.clr_wr ? clr_cnt_reg : addr_reg;
    assign ram_wdata   = cmd.clr_wr ? '0 : {1'b1, h_reg};

    pmhb_ram #(
        .WIDTH (EW),
        .DEPTH (CELLS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_rd),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Result register holds a read result until the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_occ_reg    <= inrange_reg && ram_rdata[EW-1];
            m_height_reg <= (inrange_reg && ram_rdata[EW-1]) ? ram_rdata[16:0] : '0;
        end
    end

    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = {6'd0, m_occ_reg, m_height_reg};

    // A point update always marks its cell occupied.
    a_update_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && ram_we) |-> ram_wdata[EW-1])
        else $error("point update wrote an empty cell");

    // The clear sweep writes only empty cells.
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> (ram_we && !ram_wdata[EW-1]))
        else $error("clear sweep left a cell occupied");

    // The search ends inside the grid.
    a_search_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cell_addr |-> ((ring_ans_reg <= IW'(RINGS - 1)) &&
                           (sec_ans_reg <= IW'(SECTORS - 1))))
        else $error("search left the grid");

    // A result is loaded only into a free output register.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result overwrote a pending result");

endmodule
